/* src/ccfs_pkg.sv */
// Shared constants and the CRC16/MCRF4XX byte update for the frame search.
// Used by crc_checked_frame_search; no dependencies.
`default_nettype none
package ccfs_pkg;

  localparam int FRAME_LEN = 32;
  localparam int BUF_DEPTH = 64;

  localparam int ADDR_W   = $clog2(BUF_DEPTH);
  localparam int CNT_W    = ADDR_W + 1;
  localparam int K_W      = $clog2(FRAME_LEN + 1);
  localparam int BYTE_W   = 8;
  localparam int FSTART_W = 6;
  localparam int CRC_W    = 16;

  localparam logic [CRC_W-1:0]  CRC_INIT = 16'hFFFF;
  localparam logic [CRC_W-1:0]  CRC_POLY = 16'h8408;
  localparam logic [BYTE_W-1:0] HEAD0    = 8'h53;
  localparam logic [BYTE_W-1:0] HEAD1    = 8'h50;

  // One byte of the reflected CRC: eight shift steps on a 16-bit value.
  function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] c_in,
                                                input logic [BYTE_W-1:0] d);
    logic [CRC_W-1:0] c;
    c = c_in ^ {{(CRC_W-BYTE_W){1'b0}}, d};
    for (int b = 0; b < 8; b++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage
`default_nettype wire

/* src/ccfs_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none
module ccfs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

/* src/crc_checked_frame_search.sv */
// Top level of the header and CRC16/MCRF4XX frame search over one received packet.
// Depends on ccfs_pkg and ccfs_ram.
//
// Usage: each received byte is offered on rx_byte with end_of_packet, and a
// transaction happens at a clock edge where start is high and busy is low.
// Bytes are written into a packet buffer of BUF_DEPTH entries; bytes beyond
// that are dropped. A byte without end_of_packet gives no result, and busy
// stays low.
// After an end_of_packet byte that leaves FRAME_LEN or more bytes stored, busy
// rises and a sequencer scans offsets from zero upward. Each offset reads its
// window through the buffer's single read port, one byte a cycle, and a shared
// CRC byte unit folds in every byte but the last two, which hold the stored CRC
// to compare against. A window whose header does not match is dropped as soon
// as a header byte mismatches. A found frame is then read out again, one result
// per cycle with result_valid high. A packet with no valid frame gives a single
// result with found low on the cycle after the scan ends; a short packet gives
// it on the cycle after its last byte, and busy never rises for it. busy falls
// as the last result is shown. Results are shown for one cycle each and cannot
// be held off.
// Reset clears the sequencer and counters; buffer contents are never read
// before being written for the current packet.
`default_nettype none
module crc_checked_frame_search
  import ccfs_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  output logic                     busy,
  input  wire logic [BYTE_W-1:0]   rx_byte,
  input  wire logic                end_of_packet,
  output logic                     result_valid,
  output logic      [BYTE_W-1:0]   frame_byte,
  output logic                     found,
  output logic      [FSTART_W-1:0] frame_start,
  output logic                     last_of_run
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0]        state, state_next;
  logic [CNT_W-1:0]  byte_count, byte_count_next;
  logic [CNT_W-1:0]  len, len_next;
  logic [ADDR_W-1:0] offset, offset_next;
  logic [K_W-1:0]    kcnt, kcnt_next;
  logic [K_W-1:0]    dk, dk_next;
  logic              dvalid, dvalid_next;
  logic [CRC_W-1:0]  crc, crc_next;
  logic [BYTE_W-1:0] rx_lo, rx_lo_next;

  logic                result_valid_next;
  logic [BYTE_W-1:0]   frame_byte_next;
  logic                found_next;
  logic [FSTART_W-1:0] frame_start_next;
  logic                last_of_run_next;

  logic              accept;
  logic              wr_en;
  logic [ADDR_W-1:0] raddr;
  logic [BYTE_W-1:0] rdata;
  logic [CNT_W-1:0]  raddr_full;
  logic [CNT_W:0]    next_end;
  logic              more_offsets;
  logic              issue;
  logic              fail;

  assign busy   = (state != ST_IDLE);
  assign accept = start && !busy;
  assign wr_en  = accept && (byte_count < CNT_W'(BUF_DEPTH));

  assign raddr_full = CNT_W'(offset) + CNT_W'(kcnt);
  assign raddr      = raddr_full[ADDR_W-1:0];
  assign issue      = (kcnt < K_W'(FRAME_LEN));

  // End of the window at the next offset, checked against the stored length.
  assign next_end     = (CNT_W+1)'(offset) + (CNT_W+1)'(FRAME_LEN + 1);
  assign more_offsets = (next_end <= (CNT_W+1)'(len));

  ccfs_ram #(
    .WIDTH(BYTE_W),
    .DEPTH(BUF_DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (wr_en),
    .waddr(byte_count[ADDR_W-1:0]),
    .wdata(rx_byte),
    .raddr(raddr),
    .rdata(rdata)
  );

  always_comb begin
    state_next        = state;
    byte_count_next   = byte_count;
    len_next          = len;
    offset_next       = offset;
    kcnt_next         = kcnt;
    dk_next           = dk;
    dvalid_next       = dvalid;
    crc_next          = crc;
    rx_lo_next        = rx_lo;
    result_valid_next = 1'b0;
    frame_byte_next   = frame_byte;
    found_next        = found;
    frame_start_next  = frame_start;
    last_of_run_next  = last_of_run;
    fail              = 1'b0;

    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (wr_en) begin
            byte_count_next = byte_count + CNT_W'(1);
          end
          if (end_of_packet) begin
            byte_count_next = '0;
            len_next        = byte_count + CNT_W'(wr_en);
            offset_next     = '0;
            kcnt_next       = '0;
            dvalid_next     = 1'b0;
            crc_next        = CRC_INIT;
            if (len_next >= CNT_W'(FRAME_LEN)) begin
              state_next = ST_SCAN;
            end else begin
              result_valid_next = 1'b1;
              frame_byte_next   = '0;
              found_next        = 1'b0;
              frame_start_next  = '0;
              last_of_run_next  = 1'b1;
            end
          end
        end
      end

      ST_SCAN: begin
        if (issue) begin
          kcnt_next = kcnt + K_W'(1);
        end
        dvalid_next = issue;
        dk_next     = kcnt;
        if (dvalid) begin
          if (dk <= K_W'(FRAME_LEN - 3)) begin
            crc_next = crc_byte(crc, rdata);
          end
          if (dk == K_W'(0) && rdata != HEAD0) begin
            fail = 1'b1;
          end
          if (dk == K_W'(1) && rdata != HEAD1) begin
            fail = 1'b1;
          end
          if (dk == K_W'(FRAME_LEN - 2)) begin
            rx_lo_next = rdata;
          end
          if (dk == K_W'(FRAME_LEN - 1)) begin
            if ({rdata, rx_lo} == crc) begin
              state_next  = ST_EMIT;
              kcnt_next   = '0;
              dvalid_next = 1'b0;
            end else begin
              fail = 1'b1;
            end
          end
          if (fail) begin
            kcnt_next   = '0;
            dvalid_next = 1'b0;
            crc_next    = CRC_INIT;
            if (more_offsets) begin
              offset_next = offset + ADDR_W'(1);
            end else begin
              state_next        = ST_IDLE;
              result_valid_next = 1'b1;
              frame_byte_next   = '0;
              found_next        = 1'b0;
              frame_start_next  = '0;
              last_of_run_next  = 1'b1;
            end
          end
        end
      end

      ST_EMIT: begin
        if (issue) begin
          kcnt_next = kcnt + K_W'(1);
        end
        dvalid_next = issue;
        dk_next     = kcnt;
        if (dvalid) begin
          result_valid_next = 1'b1;
          frame_byte_next   = rdata;
          found_next        = 1'b1;
          frame_start_next  = FSTART_W'(offset);
          last_of_run_next  = (dk == K_W'(FRAME_LEN - 1));
          if (dk == K_W'(FRAME_LEN - 1)) begin
            state_next  = ST_IDLE;
            dvalid_next = 1'b0;
          end
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      byte_count   <= '0;
      len          <= '0;
      offset       <= '0;
      kcnt         <= '0;
      dk           <= '0;
      dvalid       <= 1'b0;
      crc          <= CRC_INIT;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      byte_count   <= byte_count_next;
      len          <= len_next;
      offset       <= offset_next;
      kcnt         <= kcnt_next;
      dk           <= dk_next;
      dvalid       <= dvalid_next;
      crc          <= crc_next;
      result_valid <= result_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    rx_lo       <= rx_lo_next;
    frame_byte  <= frame_byte_next;
    found       <= found_next;
    frame_start <= frame_start_next;
    last_of_run <= last_of_run_next;
  end

endmodule
`default_nettype wire
